/* rtl/byte_dump_record_replay_buffer_assert.svh */
// ----------------------------------------------------------------------
// byte dump buffer assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------
`ifndef BYTE_DUMP_RECORD_REPLAY_BUFFER_ASSERT_SVH
`define BYTE_DUMP_RECORD_REPLAY_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BDRRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdrrb assertion failed");

// next-cycle implication
`define BDRRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdrrb assertion failed");

`else

`define BDRRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define BDRRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/bdrrb_pkg.sv */
// ----------------------------------------------------------------------
// bdrrb_pkg
// shared types and constants of the byte dump record and replay buffer
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

package bdrrb_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int PTR_W     = 7;
	localparam int CMD_W     = 4;
	localparam int ADDR_W    = 6;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int CFG_W     = 7;

	localparam logic [PTR_W-1:0]  MAX_RUN     = 7'd64;
	localparam logic [CFG_W-1:0]  ASIZE_RESET = 7'd64;
	localparam logic [BYTE_W-1:0] END_MARK    = 8'hF7;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 4'd0,
		CMD_READY    = 4'd1,
		CMD_RECORD   = 4'd2,
		CMD_DONE     = 4'd3,
		CMD_POKE     = 4'd4,
		CMD_PEEK     = 4'd5,
		CMD_DUMP     = 4'd6,
		CMD_CONTINUE = 4'd7,
		CMD_RANGE    = 4'd8
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA = 2'd0,
		KIND_LEN  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} gen_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		logic              last;
	} result_t;

endpackage

/* rtl/bdrrb_if.sv */
// ----------------------------------------------------------------------
// bdrrb channel interfaces
// command channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdrrb_req_if;
	logic                           valid;
	logic                           ready;
	logic [bdrrb_pkg::CMD_W-1:0]    cmd;
	logic [bdrrb_pkg::ADDR_W-1:0]   addr;
	logic                           has_addr;
	logic [bdrrb_pkg::PTR_W-1:0]    run_length;
	logic [bdrrb_pkg::ADDR_W-1:0]   end_addr;
	logic                           has_end;
	logic [bdrrb_pkg::BYTE_W-1:0]   data_byte;

	modport source (
		output valid, cmd, addr, has_addr, run_length, end_addr, has_end, data_byte,
		input  ready
	);
	modport sink (
		input  valid, cmd, addr, has_addr, run_length, end_addr, has_end, data_byte,
		output ready
	);
endinterface

interface bdrrb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bdrrb_pkg::KIND_W-1:0]   kind;
	logic [bdrrb_pkg::BYTE_W-1:0]   value;
	logic                           last;

	modport source (
		output valid, kind, value, last,
		input  ready
	);
	modport sink (
		input  valid, kind, value, last,
		output ready
	);
endinterface

/* rtl/bdrrb_rsp_fifo.sv */
// ----------------------------------------------------------------------
// bdrrb_rsp_fifo
// two-entry result queue between the read pipeline and the result channel
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module bdrrb_rsp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bdrrb_pkg::result_t  push_data,
	output logic [1:0]          level,
	bdrrb_rsp_if.source         rsp
);

	bdrrb_pkg::result_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign pop       = rsp.valid & rsp.ready;
	assign rsp.valid = (cnt_q != 2'd0);
	assign rsp.kind  = ent_q[rd_ptr_q].kind;
	assign rsp.value = ent_q[rd_ptr_q].value;
	assign rsp.last  = ent_q[rd_ptr_q].last;
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/byte_dump_record_replay_buffer.sv */
// ----------------------------------------------------------------------
// byte_dump_record_replay_buffer
// Byte store that records, replays, pokes and peeks dumps. The cells live
// in one synchronous RAM with per-cell valid flags, so reset and the clear
// commands take effect at once and no clearing pass is needed. A command
// with results streams them through the RAM read stage, fed by its single
// read port, and a two-entry result queue at one result per cycle while the
// result side keeps taking them; no new command is taken until the last read
// of a run has left the read stage. A replay that reaches the end-of-dump
// byte stops on that byte. The command channel stays open while earlier
// results still wait in the queue.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

`include "byte_dump_record_replay_buffer_assert.svh"

module byte_dump_record_replay_buffer #(
	parameter int DEPTH = bdrrb_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdrrb_pkg::CFG_W-1:0]   cfg_wdata,
	bdrrb_req_if.sink                     req,
	bdrrb_rsp_if.source                   rsp
);

	localparam int PW = bdrrb_pkg::PTR_W;
	localparam int BW = bdrrb_pkg::BYTE_W;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

	// architectural state
	logic [PW-1:0]   asize_q;
	logic [PW-1:0]   peek_ptr_q;
	logic [PW-1:0]   rec_slot_q;
	logic [PW-1:0]   rec_len_q;
	logic [PW-1:0]   replay_ptr_q;
	logic            recording_q;
	logic [DEPTH-1:0] cell_vld_q;
	logic [BW-1:0]   mem [DEPTH];

	// run generator
	bdrrb_pkg::gen_state_t gen_state_q;
	logic [PW-1:0]   cur_q;
	logic [PW-1:0]   cnt_q;
	bdrrb_pkg::kind_t gen_kind_q;
	logic [BW-1:0]   gen_const_q;
	logic            gen_mem_q;
	logic            gen_replay_q;

	// read stage
	logic            s1_valid_q;
	bdrrb_pkg::kind_t kind_s1;
	logic [BW-1:0]   const_s1;
	logic            mem_s1;
	logic            vld_s1;
	logic            last_s1;
	logic            replay_s1;
	logic [PW-1:0]   addr_s1;
	logic [BW-1:0]   rdata_s1;

	// command decode
	logic            req_fire;
	logic [PW-1:0]   lim;
	logic [PW-1:0]   p_base;
	logic [PW-1:0]   rl;
	logic [PW:0]     p_sum;
	logic [PW-1:0]   r_stop;
	logic [PW:0]     r_span;
	logic [PW-1:0]   r_cnt;
	logic [PW-1:0]   addr_x;
	logic [PW-1:0]   nxt_peek;
	logic [PW-1:0]   nxt_slot;
	logic [PW-1:0]   nxt_len;
	logic            nxt_recording;
	logic            replay_zero;
	logic            clr_all;
	logic            wr_en;
	logic [PW-1:0]   wr_addr;
	logic            st_go;
	logic [PW-1:0]   st_addr;
	logic [PW-1:0]   st_cnt;
	logic            st_mem;
	logic            st_replay;
	bdrrb_pkg::kind_t st_kind;
	logic [BW-1:0]   st_const;

	// issue and commit
	logic            pop;
	logic [1:0]      fifo_level;
	logic [2:0]      occ;
	logic            room;
	logic            issue;
	logic            kill;
	logic [BW-1:0]   value_s1;
	bdrrb_pkg::result_t push_data;

	assign req_fire  = req.valid & req.ready;
	assign req.ready = (gen_state_q == bdrrb_pkg::ST_IDLE) & ~s1_valid_q;
	assign lim       = (asize_q < DEPTH_W) ? asize_q : DEPTH_W;
	assign addr_x    = {1'b0, req.addr};

	assign p_base = req.has_addr ? addr_x : peek_ptr_q;
	assign rl     = (req.run_length == '0) ? PW'(1) :
		((req.run_length > bdrrb_pkg::MAX_RUN) ? bdrrb_pkg::MAX_RUN : req.run_length);
	assign p_sum  = {1'b0, p_base} + {1'b0, rl};
	assign r_stop = req.has_end ? {1'b0, req.end_addr} : rec_len_q;
	assign r_span = {1'b0, r_stop} - {1'b0, addr_x} + (PW+1)'(1);
	assign r_cnt  = (r_span > {1'b0, bdrrb_pkg::MAX_RUN}) ? bdrrb_pkg::MAX_RUN
		: r_span[PW-1:0];

	always_comb begin
		nxt_peek      = peek_ptr_q;
		nxt_slot      = rec_slot_q;
		nxt_len       = rec_len_q;
		nxt_recording = recording_q;
		replay_zero   = 1'b0;
		clr_all       = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = addr_x;
		st_go         = 1'b0;
		st_addr       = '0;
		st_cnt        = PW'(1);
		st_mem        = 1'b0;
		st_replay     = 1'b0;
		st_kind       = bdrrb_pkg::KIND_DATA;
		st_const      = '0;
		unique case (req.cmd)
			bdrrb_pkg::CMD_CLEAR, bdrrb_pkg::CMD_READY: begin
				clr_all  = 1'b1;
				nxt_peek = '0;
				nxt_len  = '0;
				if (req.cmd == bdrrb_pkg::CMD_READY) begin
					nxt_recording = 1'b1;
					nxt_slot      = '0;
				end
				st_go   = 1'b1;
				st_kind = bdrrb_pkg::KIND_LEN;
			end
			bdrrb_pkg::CMD_RECORD: begin
				if (recording_q) begin
					if (rec_slot_q < lim) begin
						wr_en    = 1'b1;
						wr_addr  = rec_slot_q;
						nxt_peek = rec_slot_q;
					end
					if (rec_slot_q < DEPTH_W) begin
						nxt_slot = rec_slot_q + PW'(1);
					end
				end
			end
			bdrrb_pkg::CMD_DONE: begin
				nxt_recording = 1'b0;
				nxt_len       = rec_slot_q;
				st_go         = 1'b1;
				st_kind       = bdrrb_pkg::KIND_LEN;
				st_const      = BW'(rec_slot_q);
			end
			bdrrb_pkg::CMD_POKE: begin
				if (addr_x < lim) begin
					wr_en    = 1'b1;
					nxt_peek = addr_x;
				end
			end
			bdrrb_pkg::CMD_PEEK: begin
				st_go = 1'b1;
				if (p_sum < {1'b0, lim}) begin
					st_mem   = 1'b1;
					st_addr  = p_base;
					st_cnt   = rl;
					nxt_peek = p_sum[PW-1:0];
				end else begin
					st_kind  = bdrrb_pkg::KIND_ERR;
					nxt_peek = '0;
				end
			end
			bdrrb_pkg::CMD_DUMP: begin
				if (rec_len_q != '0) begin
					replay_zero = 1'b1;
					st_go       = 1'b1;
					st_mem      = 1'b1;
					st_replay   = 1'b1;
					st_cnt      = rec_len_q;
				end
			end
			bdrrb_pkg::CMD_CONTINUE: begin
				if (replay_ptr_q < rec_len_q) begin
					st_go     = 1'b1;
					st_mem    = 1'b1;
					st_replay = 1'b1;
					st_addr   = replay_ptr_q;
					st_cnt    = rec_len_q - replay_ptr_q;
				end
			end
			bdrrb_pkg::CMD_RANGE: begin
				if (addr_x <= r_stop) begin
					st_go   = 1'b1;
					st_mem  = 1'b1;
					st_addr = addr_x;
					st_cnt  = r_cnt;
				end
			end
			default: begin
				st_go = 1'b0;
			end
		endcase
	end

	// issue one read per cycle while the queue has room for it
	assign pop      = rsp.valid & rsp.ready;
	assign occ      = {1'b0, fifo_level} + {2'b0, s1_valid_q} - {2'b0, pop};
	assign room     = (occ < 3'd2);
	assign value_s1 = mem_s1 ? (vld_s1 ? rdata_s1 : '0) : const_s1;
	assign kill     = s1_valid_q & replay_s1 & (value_s1 == bdrrb_pkg::END_MARK);
	assign issue    = (gen_state_q == bdrrb_pkg::ST_RUN) & room & ~kill;

	assign push_data.kind  = kind_s1;
	assign push_data.value = value_s1;
	assign push_data.last  = last_s1 | kill;

	always_ff @(posedge clk) begin
		if (req_fire && wr_en) begin
			mem[wr_addr[AW-1:0]] <= req.data_byte;
		end
		if (issue) begin
			rdata_s1 <= mem[cur_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1   <= gen_kind_q;
			const_s1  <= gen_const_q;
			mem_s1    <= gen_mem_q;
			vld_s1    <= (cur_q < DEPTH_W) && cell_vld_q[cur_q[AW-1:0]];
			last_s1   <= (cnt_q == PW'(1));
			replay_s1 <= gen_replay_q;
			addr_s1   <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asize_q      <= bdrrb_pkg::ASIZE_RESET;
			peek_ptr_q   <= '0;
			rec_slot_q   <= '0;
			rec_len_q    <= '0;
			replay_ptr_q <= '0;
			recording_q  <= 1'b0;
			cell_vld_q   <= '0;
			gen_state_q  <= bdrrb_pkg::ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			gen_kind_q   <= bdrrb_pkg::KIND_DATA;
			gen_const_q  <= '0;
			gen_mem_q    <= 1'b0;
			gen_replay_q <= 1'b0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				asize_q <= cfg_wdata;
			end
			s1_valid_q <= issue;
			if (s1_valid_q && replay_s1) begin
				replay_ptr_q <= addr_s1 + PW'(1);
			end
			if (req_fire) begin
				peek_ptr_q  <= nxt_peek;
				rec_slot_q  <= nxt_slot;
				rec_len_q   <= nxt_len;
				recording_q <= nxt_recording;
				if (replay_zero) begin
					replay_ptr_q <= '0;
				end
				if (clr_all) begin
					cell_vld_q <= '0;
				end
				if (wr_en) begin
					cell_vld_q[wr_addr[AW-1:0]] <= 1'b1;
				end
				if (st_go) begin
					gen_state_q  <= bdrrb_pkg::ST_RUN;
					cur_q        <= st_addr;
					cnt_q        <= st_cnt;
					gen_kind_q   <= st_kind;
					gen_const_q  <= st_const;
					gen_mem_q    <= st_mem;
					gen_replay_q <= st_replay;
				end
			end else if (kill) begin
				gen_state_q <= bdrrb_pkg::ST_IDLE;
			end else if (issue) begin
				cur_q <= cur_q + PW'(1);
				cnt_q <= cnt_q - PW'(1);
				if (cnt_q == PW'(1)) begin
					gen_state_q <= bdrrb_pkg::ST_IDLE;
				end
			end
		end
	end

	bdrrb_rsp_fifo u_rsp_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_q),
		.push_data (push_data),
		.level     (fifo_level),
		.rsp       (rsp)
	);

	// result queue never takes a transfer while full
	`BDRRB_ASSERT_IMP(a_queue_room, clk, arst_n, s1_valid_q, fifo_level != 2'd2 || pop)
	// nothing follows the final result of a run
	`BDRRB_ASSERT_NXT(a_final_ends, clk, arst_n, s1_valid_q && push_data.last, !s1_valid_q)
	// end-of-dump byte stops the replay
	`BDRRB_ASSERT_NXT(a_mark_stops, clk, arst_n, kill, gen_state_q == bdrrb_pkg::ST_IDLE)
	// slot and length stay within the store
	`BDRRB_ASSERT_IMP(a_slot_cap, clk, arst_n, 1'b1, rec_slot_q <= DEPTH_W && rec_len_q <= DEPTH_W)

endmodule

/* sim/bdrrb_checker.sv */
// ----------------------------------------------------------------------
// bdrrb_checker
// Watches the command, result and size-register ports of the byte dump
// buffer and keeps its own copy of the store, the pointers and the
// recording flag. Each accepted command queues the results it should
// cause. Each result transfer is compared field by field with the oldest
// queued one. Reports the failure count and the number of results still
// owed.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module bdrrb_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bdrrb_pkg::CFG_W-1:0] cfg_wdata,
	bdrrb_req_if                        req,
	bdrrb_rsp_if                        rsp,
	output int                          failures,
	output int                          pending
);
	import bdrrb_pkg::*;

	localparam int CELLS   = 64;
	localparam int RUN_CAP = 64;

	logic [BYTE_W-1:0] cells [CELLS];
	logic [PTR_W-1:0]  peek_ptr;
	logic [PTR_W-1:0]  rec_slot;
	logic [PTR_W-1:0]  rec_len;
	logic [PTR_W-1:0]  replay_ptr;
	logic [CFG_W-1:0]  array_size;
	logic              recording;

	result_t expected_results [$];
	result_t held;
	bit      have_held;
	int      result_count;
	int      fault_count;
	int      transfer_count;

	function automatic int usable_size();
		return (array_size < CELLS) ? int'(array_size) : CELLS;
	endfunction

	function automatic logic [BYTE_W-1:0] cell_at(input int a);
		return (a < CELLS) ? cells[a] : '0;
	endfunction

	task automatic clear_cells();
		for (int i = 0; i < CELLS; i++) begin
			cells[i] = '0;
		end
	endtask

	// the newest result is held back so that last can be set on it
	task automatic add_result(input kind_t k, input logic [BYTE_W-1:0] v);
		if (have_held) begin
			expected_results.push_back(held);
		end
		held.kind  = k;
		held.value = v;
		held.last  = 1'b0;
		have_held  = 1'b1;
		result_count++;
	endtask

	task automatic replay_dump();
		logic [BYTE_W-1:0] b;
		bit                hit_end;
		hit_end = 1'b0;
		while (!hit_end && result_count < RUN_CAP && replay_ptr < rec_len) begin
			b = cell_at(int'(replay_ptr));
			add_result(KIND_DATA, b);
			replay_ptr = replay_ptr + 1'b1;
			hit_end = (b == END_MARK);
		end
	endtask

	task automatic predict_results();
		int lim;
		int run;
		int stop;
		int i;
		lim = usable_size();
		have_held = 1'b0;
		result_count = 0;
		case (req.cmd)
			CMD_CLEAR, CMD_READY: begin
				clear_cells();
				peek_ptr = '0;
				rec_len  = '0;
				if (req.cmd == CMD_READY) begin
					recording = 1'b1;
					rec_slot  = '0;
				end
				add_result(KIND_LEN, '0);
			end
			CMD_RECORD: begin
				if (recording) begin
					if (int'(rec_slot) < lim) begin
						cells[rec_slot] = req.data_byte;
						peek_ptr = rec_slot;
					end
					if (int'(rec_slot) < CELLS) begin
						rec_slot = rec_slot + 1'b1;
					end
				end
			end
			CMD_DONE: begin
				recording = 1'b0;
				rec_len   = rec_slot;
				add_result(KIND_LEN, BYTE_W'(rec_len));
			end
			CMD_POKE: begin
				if (int'(req.addr) < lim) begin
					cells[req.addr] = req.data_byte;
					peek_ptr = PTR_W'(req.addr);
				end
			end
			CMD_PEEK: begin
				if (req.has_addr) begin
					peek_ptr = PTR_W'(req.addr);
				end
				run = int'(req.run_length);
				if (run == 0) begin
					run = 1;
				end
				if (run > RUN_CAP) begin
					run = RUN_CAP;
				end
				if (int'(peek_ptr) + run < lim) begin
					for (i = 0; i < run; i++) begin
						add_result(KIND_DATA, cell_at(int'(peek_ptr) + i));
					end
					peek_ptr = PTR_W'(int'(peek_ptr) + run);
				end else begin
					add_result(KIND_ERR, '0);
					peek_ptr = '0;
				end
			end
			CMD_DUMP: begin
				if (rec_len != 0) begin
					replay_ptr = '0;
					replay_dump();
				end
			end
			CMD_CONTINUE: begin
				replay_dump();
			end
			CMD_RANGE: begin
				stop = req.has_end ? int'(req.end_addr) : int'(rec_len);
				for (i = int'(req.addr); i <= stop && result_count < RUN_CAP; i++) begin
					add_result(KIND_DATA, cell_at(i));
				end
			end
			default: begin
			end
		endcase
		if (have_held) begin
			held.last = 1'b1;
			expected_results.push_back(held);
		end
	endtask

	task automatic check_transfer();
		result_t want;
		if (expected_results.size() == 0) begin
			fault_count++;
			if (fault_count <= 10) begin
				$display("transfer %0d: no result expected, got kind %0d value %02h last %0d",
					transfer_count, rsp.kind, rsp.value, rsp.last);
			end
		end else begin
			want = expected_results.pop_front();
			if (rsp.kind !== want.kind || rsp.value !== want.value || rsp.last !== want.last) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("transfer %0d: expected kind %0d value %02h last %0d, got kind %0d value %02h last %0d",
						transfer_count, want.kind, want.value, want.last,
						rsp.kind, rsp.value, rsp.last);
				end
			end
		end
		transfer_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cells();
			peek_ptr       = '0;
			rec_slot       = '0;
			rec_len        = '0;
			replay_ptr     = '0;
			recording      = 1'b0;
			array_size     = ASIZE_RESET;
			fault_count    = 0;
			transfer_count = 0;
			expected_results.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				check_transfer();
			end
			if (cfg_we) begin
				array_size = cfg_wdata;
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				predict_results();
			end
			failures <= fault_count;
			pending  <= expected_results.size();
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------
// testbench
// Drives the byte dump buffer: a directed run over field extremes, every
// command and the peek, replay and range corner cases, then phases of
// random record sessions and noise under several store sizes, with random
// idling on both channels, one quiet phase and one long result hold-off.
// The checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bdrrb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 4'hF;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic              has_addr;
		logic [PTR_W-1:0]  run_length;
		logic [ADDR_W-1:0] end_addr;
		logic              has_end;
		logic [BYTE_W-1:0] data_byte;
	} cmd_item_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int               failures;
	int               pending;
	int               items_sent;
	bit               quiet;
	bit               stall_go;
	bit               stall_done;
	int               stall_left;

	bdrrb_req_if req_ch ();
	bdrrb_rsp_if rsp_ch ();

	byte_dump_record_replay_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bdrrb_checker dump_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("byte_dump_record_replay_buffer: mismatch");
		$finish;
	end

	// result side: random stalls, quiet stretch, one long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		stall_done = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_go && !stall_done) begin
				stall_done = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (quiet) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 28);
			end
		end
	end

	function automatic cmd_item_t any_item();
		cmd_item_t it;
		it.cmd        = CMD_W'($urandom_range(15));
		it.addr       = ADDR_W'($urandom_range(63));
		it.has_addr   = 1'($urandom_range(1));
		it.run_length = PTR_W'($urandom_range(127));
		it.end_addr   = ADDR_W'($urandom_range(63));
		it.has_end    = 1'($urandom_range(1));
		it.data_byte  = BYTE_W'($urandom_range(255));
		return it;
	endfunction

	task automatic send_item(input cmd_item_t it);
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= it.cmd;
		req_ch.addr       <= it.addr;
		req_ch.has_addr   <= it.has_addr;
		req_ch.run_length <= it.run_length;
		req_ch.end_addr   <= it.end_addr;
		req_ch.has_end    <= it.has_end;
		req_ch.data_byte  <= it.data_byte;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		items_sent++;
		if (!quiet && $urandom_range(99) < 28) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_op(input logic [CMD_W-1:0] c, input int a, input bit ha, input int run,
			input int e, input bit he, input int d);
		cmd_item_t it;
		it.cmd        = c;
		it.addr       = a[ADDR_W-1:0];
		it.has_addr   = ha;
		it.run_length = run[PTR_W-1:0];
		it.end_addr   = e[ADDR_W-1:0];
		it.has_end    = he;
		it.data_byte  = d[BYTE_W-1:0];
		send_item(it);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_size(input int sz);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(sz);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic record_session();
		cmd_item_t it;
		int        n_rec;
		int        n_tail;
		it = any_item();
		it.cmd = CMD_READY;
		send_item(it);
		n_rec = ($urandom_range(7) == 0) ? $urandom_range(70, 30) : $urandom_range(10);
		repeat (n_rec) begin
			it = any_item();
			it.cmd = CMD_RECORD;
			if ($urandom_range(5) == 0) begin
				it.data_byte = END_MARK;
			end
			send_item(it);
		end
		it = any_item();
		it.cmd = CMD_DONE;
		send_item(it);
		n_tail = $urandom_range(8, 2);
		repeat (n_tail) begin
			it = any_item();
			case ($urandom_range(9))
				0, 1: begin
					it.cmd = CMD_DUMP;
				end
				2, 3: begin
					it.cmd = CMD_CONTINUE;
				end
				4, 5: begin
					it.cmd = CMD_PEEK;
					if ($urandom_range(3) != 0) begin
						it.run_length = PTR_W'($urandom_range(6));
					end
				end
				6: begin
					it.cmd = CMD_POKE;
				end
				7: begin
					it.cmd = CMD_RANGE;
					if ($urandom_range(1) == 1) begin
						it.end_addr = it.addr + ADDR_W'($urandom_range(5));
					end
				end
				8: begin
					it.cmd = CMD_RECORD;
				end
				default: begin
				end
			endcase
			send_item(it);
		end
	endtask

	task automatic random_phase(input int cnt);
		int goal;
		goal = items_sent + cnt;
		while (items_sent < goal) begin
			if ($urandom_range(5) == 0) begin
				repeat ($urandom_range(5, 1)) send_item(any_item());
			end else begin
				record_session();
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= '0;
		req_ch.addr       <= '0;
		req_ch.has_addr   <= 1'b0;
		req_ch.run_length <= '0;
		req_ch.end_addr   <= '0;
		req_ch.has_end    <= 1'b0;
		req_ch.data_byte  <= '0;
		quiet      = 1'b0;
		stall_go   = 1'b0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_size(64);
		send_op(CMD_UNKNOWN, 63, 1, 127, 63, 1, 255);
		send_op(CMD_PEEK, 5, 1, 0, 0, 0, 0);
		send_op(CMD_POKE, 0, 0, 0, 0, 0, 8'hFF);
		send_op(CMD_POKE, 63, 0, 0, 0, 0, 8'h5A);
		send_op(CMD_PEEK, 62, 1, 1, 0, 0, 0);
		send_op(CMD_PEEK, 0, 0, 1, 0, 0, 0);
		send_op(CMD_PEEK, 0, 0, 127, 0, 0, 0);
		send_op(CMD_PEEK, 0, 1, 63, 0, 0, 0);
		send_op(CMD_READY, 0, 0, 0, 0, 0, 0);
		send_op(CMD_RECORD, 0, 0, 0, 0, 0, 8'h00);
		send_op(CMD_RECORD, 0, 0, 0, 0, 0, END_MARK);
		send_op(CMD_RECORD, 0, 0, 0, 0, 0, 8'hFF);
		send_op(CMD_RECORD, 0, 0, 0, 0, 0, 8'h81);
		send_op(CMD_DONE, 0, 0, 0, 0, 0, 0);
		send_op(CMD_DUMP, 0, 0, 0, 0, 0, 0);
		send_op(CMD_CONTINUE, 0, 0, 0, 0, 0, 0);
		send_op(CMD_CONTINUE, 0, 0, 0, 0, 0, 0);
		send_op(CMD_RANGE, 0, 0, 0, 0, 0, 0);
		send_op(CMD_RANGE, 40, 0, 0, 39, 1, 0);
		send_op(CMD_RANGE, 0, 0, 0, 63, 1, 0);
		send_op(CMD_RECORD, 0, 0, 0, 0, 0, 8'h33);
		send_op(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send_op(CMD_DUMP, 0, 0, 0, 0, 0, 0);
		send_op(CMD_RANGE, 0, 0, 0, 0, 0, 0);

		random_phase(90);
		write_size(1);
		random_phase(50);
		write_size($urandom_range(63, 2));
		quiet = 1'b1;
		random_phase(60);
		drain_results();
		quiet = 1'b0;
		write_size(64);
		stall_go = 1'b1;
		random_phase(60);
		write_size($urandom_range(64, 1));
		random_phase(80);
		write_size(63);
		random_phase(60);

		drain_results();
		repeat (80) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("byte_dump_record_replay_buffer: match");
		end else begin
			$display("byte_dump_record_replay_buffer: mismatch");
		end
		$finish;
	end

endmodule

/* byte_dump_record_replay_buffer.f */
+incdir+rtl
rtl/bdrrb_pkg.sv
rtl/bdrrb_if.sv
rtl/bdrrb_rsp_fifo.sv
rtl/byte_dump_record_replay_buffer.sv
sim/bdrrb_checker.sv
sim/testbench.sv
